### hdl/named_cross_tally_table_macros.svh
// ----------------------------------------------------------------------------
// Named cross tally table: assertion macros
// Same-cycle and next-cycle implication checks on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef NAMED_CROSS_TALLY_TABLE_MACROS_SVH
`define NAMED_CROSS_TALLY_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define NCCT_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ncct check failed");
`define NCCT_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ncct check failed");
`else
`define NCCT_CHECK_NOW(lbl, ante, cons)
`define NCCT_CHECK_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/ncct_pkg.sv
// ----------------------------------------------------------------------------
// ncct_pkg
// Shared types, codes and widths of the named cross tally table.
// ----------------------------------------------------------------------------
`default_nettype none
package ncct_pkg;
    localparam int DEF_MAX_ROWS    = 128;
    localparam int DEF_MAX_COLUMNS = 16;
    localparam int CMD_W      = 3;
    localparam int RIDX_W     = 7;
    localparam int CIDX_W     = 4;
    localparam int KEY_W      = 64;
    localparam int CNT_W      = 32;
    localparam int VAL_W      = 44;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int RCNT_W     = 8;
    localparam int CCNT_W     = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_ROW = 3'd0,
        CMD_LOAD_COL = 3'd1,
        CMD_ADD      = 3'd2,
        CMD_CELL     = 3'd3,
        CMD_ROW_Q    = 3'd4,
        CMD_COL_Q    = 3'd5,
        CMD_SUMMARY  = 3'd6
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 3'd0,
        ST_NO_ROW = 3'd1,
        ST_NO_COL = 3'd2,
        ST_NEG    = 3'd3,
        ST_RANGE  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT = 1'd0,
        REG_COL_COUNT = 1'd1
    } t_reg;

    typedef enum logic [1:0] {
        M_ROWNAME = 2'd0,
        M_COLNAME = 2'd1,
        M_ROWMAJ  = 2'd2,
        M_COLMAJ  = 2'd3
    } t_mode;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [RIDX_W-1:0]       row_index;
        logic [CIDX_W-1:0]       column_index;
        logic [KEY_W-1:0]        row_key_low;
        logic [KEY_W-1:0]        row_key_high;
        logic [KEY_W-1:0]        column_key_low;
        logic [KEY_W-1:0]        column_key_high;
        logic signed [CNT_W-1:0] event_count;
    } t_req;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value;
        logic              is_most;
        logic              is_least;
        logic [CNT_W-1:0]  entries_seen;
        logic [CNT_W-1:0]  accepted_entries;
        logic [CNT_W-1:0]  rejected_entries;
        logic [VAL_W-1:0]  grand_total;
        logic [VAL_W-1:0]  largest_row_total;
        logic [VAL_W-1:0]  smallest_row_total;
        logic [VAL_W-1:0]  largest_column_total;
        logic [VAL_W-1:0]  smallest_column_total;
    } t_rsp;

    typedef struct packed {
        logic  in_ready;
        logic  latch;
        logic  name_wr;
        logic  scan_go;
        t_mode scan_mode;
        logic  cell_rd;
        logic  cell_use;
        logic  clr_step;
        logic  result_ld;
    } t_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             oor;
        logic             scan_done;
        logic             clr_done;
        logic             add_ok;
    } t_stat;

    function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [VAL_W-1:0] add_sat44(input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VAL_W] ? '1 : s[VAL_W-1:0];
    endfunction
endpackage
`default_nettype wire

### hdl/ncct_req_if.sv
// ----------------------------------------------------------------------------
// ncct_req_if
// Request channel: valid, ready and the request fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface ncct_req_if import ncct_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic [RIDX_W-1:0]       row_index;
    logic [CIDX_W-1:0]       column_index;
    logic [KEY_W-1:0]        row_key_low;
    logic [KEY_W-1:0]        row_key_high;
    logic [KEY_W-1:0]        column_key_low;
    logic [KEY_W-1:0]        column_key_high;
    logic signed [CNT_W-1:0] event_count;
    modport source (output valid, command, row_index, column_index, row_key_low,
                    row_key_high, column_key_low, column_key_high, event_count,
                    input ready);
    modport sink (input valid, command, row_index, column_index, row_key_low,
                  row_key_high, column_key_low, column_key_high, event_count,
                  output ready);
endinterface
`default_nettype wire

### hdl/ncct_rsp_if.sv
// ----------------------------------------------------------------------------
// ncct_rsp_if
// Result channel: valid, ready and the result fields.
// ----------------------------------------------------------------------------
`default_nettype none
interface ncct_rsp_if import ncct_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value;
    logic              is_most;
    logic              is_least;
    logic [CNT_W-1:0]  entries_seen;
    logic [CNT_W-1:0]  accepted_entries;
    logic [CNT_W-1:0]  rejected_entries;
    logic [VAL_W-1:0]  grand_total;
    logic [VAL_W-1:0]  largest_row_total;
    logic [VAL_W-1:0]  smallest_row_total;
    logic [VAL_W-1:0]  largest_column_total;
    logic [VAL_W-1:0]  smallest_column_total;
    modport source (output valid, status, value, is_most, is_least, entries_seen,
                    accepted_entries, rejected_entries, grand_total,
                    largest_row_total, smallest_row_total, largest_column_total,
                    smallest_column_total, input ready);
    modport sink (input valid, status, value, is_most, is_least, entries_seen,
                  accepted_entries, rejected_entries, grand_total,
                  largest_row_total, smallest_row_total, largest_column_total,
                  smallest_column_total, output ready);
endinterface
`default_nettype wire

### hdl/ncct_ctrl.sv
// ----------------------------------------------------------------------------
// ncct_ctrl
// Sequencer: clearing pass, request decode, name and table scans, result load.
// ----------------------------------------------------------------------------
`default_nettype none
module ncct_ctrl import ncct_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_ctl  o_ctl
);
    typedef enum logic [10:0] {
        S_CLEAR    = 11'b00000000001,
        S_IDLE     = 11'b00000000010,
        S_DECODE   = 11'b00000000100,
        S_RSCAN    = 11'b00000001000,
        S_CSCAN    = 11'b00000010000,
        S_CHECK    = 11'b00000100000,
        S_CELL_USE = 11'b00001000000,
        S_TROW     = 11'b00010000000,
        S_TCOL     = 11'b00100000000,
        S_FINISH   = 11'b01000000000,
        S_SPARE    = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ctl.in_ready = 1'b1;
                if (i_req_valid) begin
                    o_ctl.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.cmd)
                    CMD_LOAD_ROW, CMD_LOAD_COL: begin
                        o_ctl.name_wr = 1'b1;
                        n_state       = S_FINISH;
                    end
                    CMD_ADD: begin
                        o_ctl.scan_go   = 1'b1;
                        o_ctl.scan_mode = M_ROWNAME;
                        n_state         = S_RSCAN;
                    end
                    CMD_CELL: begin
                        if (i_stat.oor) begin
                            n_state = S_FINISH;
                        end else begin
                            o_ctl.cell_rd = 1'b1;
                            n_state       = S_CELL_USE;
                        end
                    end
                    CMD_ROW_Q, CMD_SUMMARY: begin
                        if (i_stat.oor) begin
                            n_state = S_FINISH;
                        end else begin
                            o_ctl.scan_go   = 1'b1;
                            o_ctl.scan_mode = M_ROWMAJ;
                            n_state         = S_TROW;
                        end
                    end
                    CMD_COL_Q: begin
                        if (i_stat.oor) begin
                            n_state = S_FINISH;
                        end else begin
                            o_ctl.scan_go   = 1'b1;
                            o_ctl.scan_mode = M_COLMAJ;
                            n_state         = S_TCOL;
                        end
                    end
                    default: n_state = S_FINISH;
                endcase
            end
            S_RSCAN: begin
                if (i_stat.scan_done) begin
                    o_ctl.scan_go   = 1'b1;
                    o_ctl.scan_mode = M_COLNAME;
                    n_state         = S_CSCAN;
                end
            end
            S_CSCAN: begin
                if (i_stat.scan_done) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.add_ok) begin
                    o_ctl.cell_rd = 1'b1;
                    n_state       = S_CELL_USE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_CELL_USE: begin
                o_ctl.cell_use = 1'b1;
                n_state        = S_FINISH;
            end
            S_TROW: begin
                if (i_stat.scan_done) begin
                    if (i_stat.cmd == CMD_SUMMARY) begin
                        o_ctl.scan_go   = 1'b1;
                        o_ctl.scan_mode = M_COLMAJ;
                        n_state         = S_TCOL;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_TCOL: begin
                if (i_stat.scan_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_out_free) begin
                    o_ctl.result_ld = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### hdl/ncct_dp.sv
// ----------------------------------------------------------------------------
// ncct_dp
// Datapath: name stores, tally memory, scan counters, totals and counters.
// ----------------------------------------------------------------------------
`default_nettype none
module ncct_dp import ncct_pkg::*; #(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_ctl                  i_ctl,
    input  t_req                  i_req,
    output t_stat                 o_stat,
    output t_rsp                  o_rsp
);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int IW    = (RW > CW) ? RW : CW;
    localparam int NRW   = $clog2(MAX_ROWS + 1);
    localparam int NCW   = $clog2(MAX_COLUMNS + 1);
    localparam int LW    = (NRW > NCW) ? NRW : NCW;
    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [RCNT_W-1:0] r_row_count;
    logic [CCNT_W-1:0] r_col_count;
    t_req              r_req;
    logic [NRW-1:0]    w_nr;
    logic [NCW-1:0]    w_nc;
    logic              w_oor;

    logic [2*KEY_W-1:0] r_rnames [MAX_ROWS];
    logic [2*KEY_W-1:0] r_cnames [MAX_COLUMNS];
    logic [MAX_ROWS-1:0]    r_rvalid;
    logic [MAX_COLUMNS-1:0] r_cvalid;
    logic [2*KEY_W-1:0] r_rn_q, r_cn_q;
    logic               r_rv_q, r_cv_q;

    logic [CNT_W-1:0] r_cells [DEPTH];
    logic [CNT_W-1:0] r_cell_q;
    logic [AW-1:0]    r_cell_addr, r_clr;
    logic [AW-1:0]    w_cell_ra, w_cell_wa, w_cell_sel, w_scan_addr;
    logic [CNT_W-1:0] w_cell_wd;
    logic             w_cell_we;
    logic [CNT_W:0]   w_cell_sum;

    logic          r_run;
    t_mode         r_mode, r_pmode;
    logic [IW-1:0] r_si, r_so, r_pi, r_po;
    logic          r_pv, r_pend, r_plast;
    logic [LW-1:0] w_lim_in, w_lim_out;
    logic          w_in_last, w_out_last;

    logic          r_rhit, r_chit;
    logic [RW-1:0] r_rhit_idx;
    logic [CW-1:0] r_chit_idx;

    logic [VAL_W-1:0] r_acc, r_val, r_grand;
    logic [VAL_W-1:0] r_rmost, r_rleast, r_cmost, r_cleast;
    logic [VAL_W-1:0] w_tot;
    logic             w_is_line;

    logic [CNT_W-1:0] r_ent, r_okc, r_rej, n_ent, n_okc, n_rej;
    logic             w_add_ok;
    t_status          w_add_st, w_status;
    t_rsp             r_rsp;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= RCNT_W'(1);
            r_col_count <= CCNT_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_ROW_COUNT) r_row_count <= i_cfg_data[RCNT_W-1:0];
            else r_col_count <= i_cfg_data[CCNT_W-1:0];
        end
    end

    always_comb begin
        if (r_row_count == '0) w_nr = NRW'(1);
        else if (32'(r_row_count) > 32'(MAX_ROWS)) w_nr = NRW'(MAX_ROWS);
        else w_nr = NRW'(r_row_count);
        if (r_col_count == '0) w_nc = NCW'(1);
        else if (32'(r_col_count) > 32'(MAX_COLUMNS)) w_nc = NCW'(MAX_COLUMNS);
        else w_nc = NCW'(r_col_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) r_req <= i_req;
    end

    always_comb begin
        case (r_req.command)
            CMD_LOAD_ROW: w_oor = 32'(r_req.row_index) >= 32'(MAX_ROWS);
            CMD_LOAD_COL: w_oor = 32'(r_req.column_index) >= 32'(MAX_COLUMNS);
            CMD_CELL:     w_oor = (32'(r_req.row_index) >= 32'(w_nr))
                                || (32'(r_req.column_index) >= 32'(w_nc));
            CMD_ROW_Q:    w_oor = 32'(r_req.row_index) >= 32'(w_nr);
            CMD_COL_Q:    w_oor = 32'(r_req.column_index) >= 32'(w_nc);
            default:      w_oor = 1'b0;
        endcase
    end

    // scan counters
    always_comb begin
        case (r_mode)
            M_ROWNAME: begin w_lim_in = LW'(w_nr); w_lim_out = LW'(1);    end
            M_COLNAME: begin w_lim_in = LW'(w_nc); w_lim_out = LW'(1);    end
            M_ROWMAJ:  begin w_lim_in = LW'(w_nc); w_lim_out = LW'(w_nr); end
            default:   begin w_lim_in = LW'(w_nr); w_lim_out = LW'(w_nc); end
        endcase
        w_in_last  = (32'(r_si) + 32'd1) == 32'(w_lim_in);
        w_out_last = (32'(r_so) + 32'd1) == 32'(w_lim_out);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_pv  <= 1'b0;
        end else begin
            r_pv <= r_run;
            if (i_ctl.scan_go) begin
                r_run <= 1'b1;
            end else if (r_run && w_in_last && w_out_last) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pi    <= r_si;
        r_po    <= r_so;
        r_pend  <= w_in_last;
        r_plast <= w_in_last && w_out_last;
        r_pmode <= r_mode;
        if (i_ctl.scan_go) begin
            r_mode <= i_ctl.scan_mode;
            r_si   <= '0;
            r_so   <= '0;
        end else if (r_run) begin
            if (w_in_last) begin
                r_si <= '0;
                if (!w_out_last) r_so <= r_so + IW'(1);
            end else begin
                r_si <= r_si + IW'(1);
            end
        end
    end

    // name stores
    always_ff @(posedge i_clk) begin
        if (i_ctl.name_wr && !w_oor && r_req.command == CMD_LOAD_ROW) begin
            r_rnames[RW'(r_req.row_index)] <= {r_req.row_key_high, r_req.row_key_low};
        end
        if (i_ctl.name_wr && !w_oor && r_req.command == CMD_LOAD_COL) begin
            r_cnames[CW'(r_req.column_index)] <= {r_req.column_key_high,
                                                  r_req.column_key_low};
        end
        r_rn_q <= r_rnames[r_si[RW-1:0]];
        r_cn_q <= r_cnames[r_si[CW-1:0]];
        r_rv_q <= r_rvalid[r_si[RW-1:0]];
        r_cv_q <= r_cvalid[r_si[CW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvalid <= '0;
            r_cvalid <= '0;
        end else if (i_ctl.name_wr && !w_oor) begin
            if (r_req.command == CMD_LOAD_ROW) r_rvalid[RW'(r_req.row_index)] <= 1'b1;
            if (r_req.command == CMD_LOAD_COL) r_cvalid[CW'(r_req.column_index)] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.scan_go && i_ctl.scan_mode == M_ROWNAME) r_rhit <= 1'b0;
        if (i_ctl.scan_go && i_ctl.scan_mode == M_COLNAME) r_chit <= 1'b0;
        if (r_pv && r_pmode == M_ROWNAME
            && (r_rv_q ? r_rn_q : '0) == {r_req.row_key_high, r_req.row_key_low}) begin
            r_rhit     <= 1'b1;
            r_rhit_idx <= r_pi[RW-1:0];
        end
        if (r_pv && r_pmode == M_COLNAME
            && (r_cv_q ? r_cn_q : '0) == {r_req.column_key_high, r_req.column_key_low})
        begin
            r_chit     <= 1'b1;
            r_chit_idx <= r_pi[CW-1:0];
        end
    end

    // tally memory
    always_comb begin
        if (r_mode == M_ROWMAJ) w_scan_addr = AW'(32'(r_so) * 32'(MAX_COLUMNS) + 32'(r_si));
        else w_scan_addr = AW'(32'(r_si) * 32'(MAX_COLUMNS) + 32'(r_so));
        if (r_req.command == CMD_ADD)
            w_cell_sel = AW'(32'(r_rhit_idx) * 32'(MAX_COLUMNS) + 32'(r_chit_idx));
        else
            w_cell_sel = AW'(32'(r_req.row_index) * 32'(MAX_COLUMNS)
                             + 32'(r_req.column_index));
        w_cell_ra  = i_ctl.cell_rd ? w_cell_sel : w_scan_addr;
        w_cell_sum = {1'b0, r_cell_q} + {1'b0, r_req.event_count};
        w_cell_we  = i_ctl.clr_step || (i_ctl.cell_use && r_req.command == CMD_ADD);
        w_cell_wa  = i_ctl.clr_step ? r_clr : r_cell_addr;
        w_cell_wd  = i_ctl.clr_step ? '0
                   : (w_cell_sum[CNT_W] ? '1 : w_cell_sum[CNT_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (w_cell_we) r_cells[w_cell_wa] <= w_cell_wd;
        r_cell_q <= r_cells[w_cell_ra];
        if (i_ctl.cell_rd) r_cell_addr <= w_cell_sel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_ctl.clr_step) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // totals and extremes
    assign w_tot = add_sat44(r_acc, VAL_W'(r_cell_q));
    assign w_is_line = (r_pmode == M_ROWMAJ) ? (32'(r_po) == 32'(r_req.row_index))
                                             : (32'(r_po) == 32'(r_req.column_index));

    always_ff @(posedge i_clk) begin
        if (i_ctl.cell_use && r_req.command == CMD_CELL) r_val <= VAL_W'(r_cell_q);
        if (r_pv && (r_pmode == M_ROWMAJ || r_pmode == M_COLMAJ)) begin
            if (r_pend) begin
                r_acc <= '0;
                if (w_is_line) r_val <= w_tot;
                if (r_pmode == M_ROWMAJ) begin
                    if (w_tot > r_rmost)  r_rmost  <= w_tot;
                    if (w_tot < r_rleast) r_rleast <= w_tot;
                end else begin
                    if (w_tot > r_cmost)  r_cmost  <= w_tot;
                    if (w_tot < r_cleast) r_cleast <= w_tot;
                    r_grand <= add_sat44(r_grand, w_tot);
                end
            end else begin
                r_acc <= w_tot;
            end
        end
        if (i_ctl.scan_go && i_ctl.scan_mode == M_ROWMAJ) begin
            r_acc    <= '0;
            r_rmost  <= '0;
            r_rleast <= '1;
        end
        if (i_ctl.scan_go && i_ctl.scan_mode == M_COLMAJ) begin
            r_acc    <= '0;
            r_cmost  <= '0;
            r_cleast <= '1;
            r_grand  <= '0;
        end
    end

    // status and counters
    assign w_add_ok = r_rhit && r_chit && !r_req.event_count[CNT_W-1];

    always_comb begin
        if (!r_rhit) w_add_st = ST_NO_ROW;
        else if (!r_chit) w_add_st = ST_NO_COL;
        else if (r_req.event_count[CNT_W-1]) w_add_st = ST_NEG;
        else w_add_st = ST_OK;
        case (r_req.command)
            CMD_LOAD_ROW, CMD_LOAD_COL, CMD_CELL, CMD_ROW_Q, CMD_COL_Q:
                w_status = w_oor ? ST_RANGE : ST_OK;
            CMD_ADD:     w_status = w_add_st;
            CMD_SUMMARY: w_status = ST_OK;
            default:     w_status = ST_RANGE;
        endcase
        n_ent = r_ent;
        n_okc = r_okc;
        n_rej = r_rej;
        if (r_req.command == CMD_ADD) begin
            n_ent = inc_sat(r_ent);
            if (w_add_ok) n_okc = inc_sat(r_okc);
            else n_rej = inc_sat(r_rej);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent <= '0;
            r_okc <= '0;
            r_rej <= '0;
        end else if (i_ctl.result_ld) begin
            r_ent <= n_ent;
            r_okc <= n_okc;
            r_rej <= n_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.result_ld) begin
            r_rsp                  <= '0;
            r_rsp.status           <= w_status;
            r_rsp.entries_seen     <= n_ent;
            r_rsp.accepted_entries <= n_okc;
            r_rsp.rejected_entries <= n_rej;
            if (!w_oor && (r_req.command == CMD_CELL || r_req.command == CMD_ROW_Q
                           || r_req.command == CMD_COL_Q)) begin
                r_rsp.value <= r_val;
            end
            if (!w_oor && r_req.command == CMD_ROW_Q) begin
                r_rsp.is_most  <= r_val == r_rmost;
                r_rsp.is_least <= r_val == r_rleast;
            end
            if (!w_oor && r_req.command == CMD_COL_Q) begin
                r_rsp.is_most  <= r_val == r_cmost;
                r_rsp.is_least <= r_val == r_cleast;
            end
            if (r_req.command == CMD_SUMMARY) begin
                r_rsp.grand_total           <= r_grand;
                r_rsp.largest_row_total     <= r_rmost;
                r_rsp.smallest_row_total    <= r_rleast;
                r_rsp.largest_column_total  <= r_cmost;
                r_rsp.smallest_column_total <= r_cleast;
            end
        end
    end

    assign o_rsp            = r_rsp;
    assign o_stat.cmd       = r_req.command;
    assign o_stat.oor       = w_oor;
    assign o_stat.scan_done = r_pv && r_plast;
    assign o_stat.clr_done  = r_clr == AW'(DEPTH - 1);
    assign o_stat.add_ok    = w_add_ok;
endmodule
`default_nettype wire

### hdl/named_cross_tally_table.sv
// ----------------------------------------------------------------------------
// named_cross_tally_table
// Two-dimensional tally addressed by row and column names.
//
//   channel   dir  handshake      contents
//   i_req     in   valid/ready    command, indexes, keys, count
//   o_rsp     out  valid/ready    status, value, flags, counters, totals
//   i_cfg_*   in   write enable   row_count, column_count
//
// One request at a time. Loads, out of range queries and undefined commands
// go straight to the result and a cell query reads one tally cell. An add
// entry walks the row names and then the column names through the name
// stores and, unless rejected, updates its cell; a row or column query walks
// the tally memory once and a summary twice (one tally memory read a cycle).
// A result waits until the held one has left. After reset a clearing pass
// zeroes all MAX_ROWS x MAX_COLUMNS cells of the tally memory; no request is
// taken until it ends. A held result does not block the next request.
// ----------------------------------------------------------------------------
`default_nettype none
`include "named_cross_tally_table_macros.svh"
module named_cross_tally_table import ncct_pkg::*; #(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ncct_req_if.sink              i_req,
    ncct_rsp_if.source            o_rsp
);
    t_ctl  w_ctl;
    t_stat w_stat;
    t_req  w_req;
    t_rsp  w_rsp;
    logic  r_out_valid;
    logic  w_out_free;

    assign w_req.command         = i_req.command;
    assign w_req.row_index       = i_req.row_index;
    assign w_req.column_index    = i_req.column_index;
    assign w_req.row_key_low     = i_req.row_key_low;
    assign w_req.row_key_high    = i_req.row_key_high;
    assign w_req.column_key_low  = i_req.column_key_low;
    assign w_req.column_key_high = i_req.column_key_high;
    assign w_req.event_count     = i_req.event_count;

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_ctl.in_ready;

    ncct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_out_free  (w_out_free),
        .i_stat      (w_stat),
        .o_ctl       (w_ctl)
    );

    ncct_dp #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_ctl       (w_ctl),
        .i_req       (w_req),
        .o_stat      (w_stat),
        .o_rsp       (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.result_ld) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid                 = r_out_valid;
    assign o_rsp.status                = w_rsp.status;
    assign o_rsp.value                 = w_rsp.value;
    assign o_rsp.is_most               = w_rsp.is_most;
    assign o_rsp.is_least              = w_rsp.is_least;
    assign o_rsp.entries_seen          = w_rsp.entries_seen;
    assign o_rsp.accepted_entries      = w_rsp.accepted_entries;
    assign o_rsp.rejected_entries      = w_rsp.rejected_entries;
    assign o_rsp.grand_total           = w_rsp.grand_total;
    assign o_rsp.largest_row_total     = w_rsp.largest_row_total;
    assign o_rsp.smallest_row_total    = w_rsp.smallest_row_total;
    assign o_rsp.largest_column_total  = w_rsp.largest_column_total;
    assign o_rsp.smallest_column_total = w_rsp.smallest_column_total;

    `NCCT_CHECK_NEXT(a_one_request, i_req.valid && i_req.ready, !i_req.ready)
    `NCCT_CHECK_NOW(a_no_overwrite, w_ctl.result_ld, !r_out_valid || o_rsp.ready)
    `NCCT_CHECK_NEXT(a_range_status, w_ctl.result_ld && w_stat.oor, o_rsp.status == ST_RANGE)
endmodule
`default_nettype wire

### bench/ncct_checker.sv
// ----------------------------------------------------------------------------
// ncct_checker
// Watches the request, result and register write ports of the named cross
// tally table, keeps its own copy of the name stores, tally cells and
// counters, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module ncct_checker import ncct_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ncct_req_if                   i_req,
    ncct_rsp_if                   i_rsp,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [VAL_W-1:0] TOTAL_MAX = '1;

    logic [KEY_W-1:0]  row_lo [DEF_MAX_ROWS];
    logic [KEY_W-1:0]  row_hi [DEF_MAX_ROWS];
    logic [KEY_W-1:0]  col_lo [DEF_MAX_COLUMNS];
    logic [KEY_W-1:0]  col_hi [DEF_MAX_COLUMNS];
    logic [CNT_W-1:0]  tally [DEF_MAX_ROWS][DEF_MAX_COLUMNS];
    logic [CNT_W-1:0]  seen_cnt, taken_cnt, refused_cnt;
    logic [RCNT_W-1:0] row_count_reg;
    logic [CCNT_W-1:0] col_count_reg;
    t_rsp              pending_results[$];

    initial o_fail_count = 0;

    function automatic int rows_in_use();
        int r;
        r = (row_count_reg == 0) ? 1 : int'(row_count_reg);
        return (r > DEF_MAX_ROWS) ? DEF_MAX_ROWS : r;
    endfunction

    function automatic int cols_in_use();
        int c;
        c = (col_count_reg == 0) ? 1 : int'(col_count_reg);
        return (c > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : c;
    endfunction

    function automatic logic [VAL_W-1:0] clamp_total(logic [63:0] v);
        return (v > 64'(TOTAL_MAX)) ? TOTAL_MAX : v[VAL_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [VAL_W-1:0] row_sum(int r);
        logic [63:0] s;
        s = 0;
        for (int c = 0; c < cols_in_use(); c++) s += tally[r][c];
        return clamp_total(s);
    endfunction

    function automatic logic [VAL_W-1:0] col_sum(int c);
        logic [63:0] s;
        s = 0;
        for (int r = 0; r < rows_in_use(); r++) s += tally[r][c];
        return clamp_total(s);
    endfunction

    function automatic void row_span(output logic [VAL_W-1:0] hi, output logic [VAL_W-1:0] lo);
        logic [VAL_W-1:0] t;
        hi = 0;
        lo = TOTAL_MAX;
        for (int r = 0; r < rows_in_use(); r++) begin
            t = row_sum(r);
            if (t > hi) hi = t;
            if (t < lo) lo = t;
        end
    endfunction

    function automatic void col_span(output logic [VAL_W-1:0] hi, output logic [VAL_W-1:0] lo);
        logic [VAL_W-1:0] t;
        hi = 0;
        lo = TOTAL_MAX;
        for (int c = 0; c < cols_in_use(); c++) begin
            t = col_sum(c);
            if (t > hi) hi = t;
            if (t < lo) lo = t;
        end
    endfunction

    function automatic t_rsp apply_request(t_req q);
        t_rsp e;
        int nr, nc, hit_r, hit_c;
        logic [VAL_W-1:0] hi, lo;
        logic [32:0] s;
        logic [63:0] g;
        e = '0;
        nr = rows_in_use();
        nc = cols_in_use();
        case (q.command)
            CMD_LOAD_ROW: begin
                if (int'(q.row_index) >= DEF_MAX_ROWS) e.status = ST_RANGE;
                else begin
                    row_lo[q.row_index] = q.row_key_low;
                    row_hi[q.row_index] = q.row_key_high;
                end
            end
            CMD_LOAD_COL: begin
                if (int'(q.column_index) >= DEF_MAX_COLUMNS) e.status = ST_RANGE;
                else begin
                    col_lo[q.column_index] = q.column_key_low;
                    col_hi[q.column_index] = q.column_key_high;
                end
            end
            CMD_ADD: begin
                seen_cnt = bump(seen_cnt);
                hit_r = -1;
                hit_c = -1;
                for (int m = 0; m < nr; m++)
                    if (row_lo[m] == q.row_key_low && row_hi[m] == q.row_key_high) hit_r = m;
                for (int m = 0; m < nc; m++)
                    if (col_lo[m] == q.column_key_low && col_hi[m] == q.column_key_high)
                        hit_c = m;
                if (hit_r < 0) e.status = ST_NO_ROW;
                else if (hit_c < 0) e.status = ST_NO_COL;
                else if (q.event_count < 0) e.status = ST_NEG;
                if (e.status != ST_OK) refused_cnt = bump(refused_cnt);
                else begin
                    s = {1'b0, tally[hit_r][hit_c]} + {1'b0, q.event_count};
                    tally[hit_r][hit_c] = s[32] ? '1 : s[31:0];
                    taken_cnt = bump(taken_cnt);
                end
            end
            CMD_CELL: begin
                if (int'(q.row_index) >= nr || int'(q.column_index) >= nc) e.status = ST_RANGE;
                else e.value = VAL_W'(tally[q.row_index][q.column_index]);
            end
            CMD_ROW_Q: begin
                if (int'(q.row_index) >= nr) e.status = ST_RANGE;
                else begin
                    e.value = row_sum(q.row_index);
                    row_span(hi, lo);
                    e.is_most = (e.value == hi);
                    e.is_least = (e.value == lo);
                end
            end
            CMD_COL_Q: begin
                if (int'(q.column_index) >= nc) e.status = ST_RANGE;
                else begin
                    e.value = col_sum(q.column_index);
                    col_span(hi, lo);
                    e.is_most = (e.value == hi);
                    e.is_least = (e.value == lo);
                end
            end
            CMD_SUMMARY: begin
                g = 0;
                for (int c = 0; c < nc; c++) g += col_sum(c);
                e.grand_total = clamp_total(g);
                row_span(e.largest_row_total, e.smallest_row_total);
                col_span(e.largest_column_total, e.smallest_column_total);
            end
            default: e.status = ST_RANGE;
        endcase
        e.entries_seen = seen_cnt;
        e.accepted_entries = taken_cnt;
        e.rejected_entries = refused_cnt;
        return e;
    endfunction

    task automatic report(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_req q;
        t_rsp e;
        if (!i_rst_n) begin
            foreach (row_lo[i]) begin
                row_lo[i] = '0;
                row_hi[i] = '0;
            end
            foreach (col_lo[i]) begin
                col_lo[i] = '0;
                col_hi[i] = '0;
            end
            foreach (tally[r, c]) tally[r][c] = '0;
            seen_cnt = '0;
            taken_cnt = '0;
            refused_cnt = '0;
            row_count_reg = 1;
            col_count_reg = 1;
            pending_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ROW_COUNT) row_count_reg = i_cfg_data[RCNT_W-1:0];
                else col_count_reg = i_cfg_data[CCNT_W-1:0];
            end
            if (i_req.valid && i_req.ready) begin
                q.command = i_req.command;
                q.row_index = i_req.row_index;
                q.column_index = i_req.column_index;
                q.row_key_low = i_req.row_key_low;
                q.row_key_high = i_req.row_key_high;
                q.column_key_low = i_req.column_key_low;
                q.column_key_high = i_req.column_key_high;
                q.event_count = i_req.event_count;
                pending_results.push_back(apply_request(q));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_results.size() == 0) report("result with no request outstanding");
                else begin
                    e = pending_results.pop_front();
                    check_field("status", i_rsp.status, e.status);
                    check_field("value", i_rsp.value, e.value);
                    check_field("is_most", i_rsp.is_most, e.is_most);
                    check_field("is_least", i_rsp.is_least, e.is_least);
                    check_field("entries_seen", i_rsp.entries_seen, e.entries_seen);
                    check_field("accepted_entries", i_rsp.accepted_entries,
                                e.accepted_entries);
                    check_field("rejected_entries", i_rsp.rejected_entries,
                                e.rejected_entries);
                    check_field("grand_total", i_rsp.grand_total, e.grand_total);
                    check_field("largest_row_total", i_rsp.largest_row_total,
                                e.largest_row_total);
                    check_field("smallest_row_total", i_rsp.smallest_row_total,
                                e.smallest_row_total);
                    check_field("largest_column_total", i_rsp.largest_column_total,
                                e.largest_column_total);
                    check_field("smallest_column_total", i_rsp.smallest_column_total,
                                e.smallest_column_total);
                end
            end
        end
        o_pending <= pending_results.size();
    end
endmodule
`default_nettype wire

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the named cross tally table through directed name, entry and query
// cases, then random request streams over several table shapes with random
// stalls on both channels; the checker beside the block judges each result.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top import ncct_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;
    int                    sent_count = 0;
    int                    stall_left = 0;
    bit                    idle_on = 1'b1;
    int                    rows_eff = 1;
    int                    cols_eff = 1;
    logic [127:0]          row_pool [8];
    logic [127:0]          col_pool [8];

    ncct_req_if req_if();
    ncct_rsp_if rsp_if();

    named_cross_tally_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    ncct_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.command = '0;
        req_if.row_index = '0;
        req_if.column_index = '0;
        req_if.row_key_low = '0;
        req_if.row_key_high = '0;
        req_if.column_key_low = '0;
        req_if.column_key_high = '0;
        req_if.event_count = '0;
        rsp_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    initial begin
        #20_000_000;
        $display("named_cross_tally_table verification failed");
        $finish;
    end

    function automatic t_req mk(logic [2:0] cmd, int ri, int ci, logic [127:0] rk,
                                logic [127:0] ck, logic [31:0] cnt);
        t_req q;
        q.command = cmd;
        q.row_index = RIDX_W'(ri);
        q.column_index = CIDX_W'(ci);
        {q.row_key_high, q.row_key_low} = rk;
        {q.column_key_high, q.column_key_low} = ck;
        q.event_count = cnt;
        return q;
    endfunction

    function automatic logic [127:0] pick_key(bit is_row);
        if ($urandom_range(0, 99) < 85)
            return is_row ? row_pool[$urandom_range(0, 7)] : col_pool[$urandom_range(0, 7)];
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic t_req random_request();
        int pick;
        logic [2:0] cmd;
        int ri, ci;
        logic [31:0] cnt;
        pick = $urandom_range(0, 99);
        if (pick < 2) cmd = 3'd7;
        else if (pick < 17) cmd = CMD_LOAD_ROW;
        else if (pick < 25) cmd = CMD_LOAD_COL;
        else if (pick < 70) cmd = CMD_ADD;
        else if (pick < 78) cmd = CMD_CELL;
        else if (pick < 86) cmd = CMD_ROW_Q;
        else if (pick < 94) cmd = CMD_COL_Q;
        else cmd = CMD_SUMMARY;
        ri = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, rows_eff - 1);
        ci = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, cols_eff - 1);
        pick = $urandom_range(0, 9);
        if (pick < 7) cnt = $urandom_range(0, 1000);
        else if (pick == 7) cnt = $urandom | 32'h8000_0000;
        else if (pick == 8) cnt = $urandom;
        else cnt = 32'h7FFF_0000 | $urandom_range(0, 32'hFFFF);
        return mk(cmd, ri, ci, pick_key(1'b1), pick_key(1'b0), cnt);
    endfunction

    task automatic send(t_req q);
        req_if.valid <= 1'b1;
        req_if.command <= q.command;
        req_if.row_index <= q.row_index;
        req_if.column_index <= q.column_index;
        req_if.row_key_low <= q.row_key_low;
        req_if.row_key_high <= q.row_key_high;
        req_if.column_key_low <= q.column_key_low;
        req_if.column_key_high <= q.column_key_high;
        req_if.event_count <= q.event_count;
        do @(posedge i_clk); while (!req_if.ready);
        sent_count++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic set_shape(logic [7:0] rows, logic [7:0] cols);
        int r, c;
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        cfg_we <= 1'b1;
        cfg_index <= REG_ROW_COUNT;
        cfg_data <= rows;
        @(posedge i_clk);
        cfg_index <= REG_COL_COUNT;
        cfg_data <= cols;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        r = (rows == 0) ? 1 : int'(rows);
        c = (cols[4:0] == 0) ? 1 : int'(cols[4:0]);
        rows_eff = (r > DEF_MAX_ROWS) ? DEF_MAX_ROWS : r;
        cols_eff = (c > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : c;
    endtask

    initial begin
        int ph_rows [7] = '{0, 5, 16, 255, 3, 9, 2};
        int ph_cols [7] = '{0, 3, 8, 255, 2, 16, 1};
        int ph_items [7] = '{60, 220, 300, 30, 150, 220, 150};
        logic [127:0] ka, kb, ones;
        row_pool[0] = '0;
        col_pool[0] = '0;
        row_pool[1] = '1;
        col_pool[1] = '1;
        for (int i = 2; i < 8; i++) begin
            row_pool[i] = {$urandom, $urandom, $urandom, $urandom};
            col_pool[i] = {$urandom, $urandom, $urandom, $urandom};
        end
        ka = row_pool[2];
        kb = col_pool[2];
        ones = '1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(mk(CMD_SUMMARY, 0, 0, 0, 0, 0));
        send(mk(CMD_ADD, 0, 0, 0, 0, 5));
        send(mk(CMD_ADD, 0, 0, 0, 0, -1));
        send(mk(CMD_LOAD_ROW, 0, 0, ka, 0, 0));
        send(mk(CMD_ADD, 0, 0, 0, 0, -3));
        send(mk(CMD_LOAD_COL, 0, 0, 0, kb, 0));
        send(mk(CMD_ADD, 0, 0, ka, 0, 3));
        send(mk(CMD_ADD, 0, 0, ka, kb, -5));
        repeat (3) send(mk(CMD_ADD, 0, 0, ka, kb, 32'h7FFF_FFFF));
        send(mk(CMD_CELL, 0, 0, 0, 0, 0));
        send(mk(CMD_CELL, 1, 0, 0, 0, 0));
        send(mk(CMD_CELL, 0, 1, 0, 0, 0));
        send(mk(CMD_ROW_Q, 0, 0, 0, 0, 0));
        send(mk(CMD_ROW_Q, 127, 0, 0, 0, 0));
        send(mk(CMD_COL_Q, 0, 0, 0, 0, 0));
        send(mk(CMD_COL_Q, 0, 15, 0, 0, 0));
        send(mk(3'd7, 127, 15, ones, ones, 32'hFFFF_FFFF));
        send(mk(CMD_LOAD_ROW, 127, 0, ones, 0, 0));
        send(mk(CMD_LOAD_COL, 0, 15, 0, ones, 0));
        send(mk(CMD_ADD, 0, 0, ones, ones, 32'h8000_0000));
        set_shape(3, 2);
        send(mk(CMD_LOAD_ROW, 2, 0, ka, 0, 0));
        send(mk(CMD_ADD, 0, 0, ka, kb, 7));
        send(mk(CMD_ROW_Q, 2, 0, 0, 0, 0));
        send(mk(CMD_ROW_Q, 1, 0, 0, 0, 0));
        send(mk(CMD_SUMMARY, 0, 0, 0, 0, 0));

        foreach (ph_rows[p]) begin
            set_shape(ph_rows[p], ph_cols[p]);
            idle_on = (p != 2);
            for (int n = 0; n < ph_items[p]; n++) begin
                if (p == 6 && n == 50) idle_on = 1'b0;
                send(random_request());
            end
        end

        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
        $display("covered %0d requests over %0d table shapes, from 1x1 up to 128x16,",
                 sent_count, 8);
        $display("with name loads, entries, rejects, saturation and all query kinds");
        if (fail_count == 0) begin
            $display("named_cross_tally_table verification clean");
        end else begin
            $display("named_cross_tally_table verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

### named_cross_tally_table.f
+incdir+hdl
hdl/ncct_pkg.sv
hdl/ncct_req_if.sv
hdl/ncct_rsp_if.sv
hdl/ncct_ctrl.sv
hdl/ncct_dp.sv
hdl/named_cross_tally_table.sv
bench/ncct_checker.sv
bench/tb_top.sv
